### hdl/ialu_pkg.sv
// shared operation codes and pipeline control type for the integer alu
package ialu_pkg;

   typedef enum logic [1:0] {
      FUNC_ADD = 2'd0,
      FUNC_SUB = 2'd1,
      FUNC_MUL = 2'd2,
      FUNC_DIV = 2'd3
   } func_type;

   typedef struct packed {
      logic     vld;
      func_type func;
      logic     carry;
      logic     dz;
      logic     sa;
      logic     sb;
   } ctl_type;

endpackage

### hdl/ialu_cell.sv
// one pipeline cell: one restoring divide step and one shift-add multiply step
module ialu_cell #(
   parameter int WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  ialu_pkg::ctl_type    ctl_i,
   input  logic [WIDTH-1:0]     a_i,
   input  logic [WIDTH-1:0]     b_i,
   input  logic [WIDTH-1:0]     num_i,
   input  logic [WIDTH-1:0]     den_i,
   input  logic [WIDTH-1:0]     rem_i,
   input  logic [WIDTH-1:0]     quo_i,
   input  logic [WIDTH-1:0]     acc_i,
   output ialu_pkg::ctl_type    ctl_o,
   output logic [WIDTH-1:0]     a_o,
   output logic [WIDTH-1:0]     b_o,
   output logic [WIDTH-1:0]     num_o,
   output logic [WIDTH-1:0]     den_o,
   output logic [WIDTH-1:0]     rem_o,
   output logic [WIDTH-1:0]     quo_o,
   output logic [WIDTH-1:0]     acc_o
);
   import ialu_pkg::*;

   ctl_type          ctl_ff;
   logic [WIDTH-1:0] a_ff, b_ff, num_ff, den_ff, rem_ff, quo_ff, acc_ff;
   logic [WIDTH-1:0] b_in, num_in, rem_in, quo_in, acc_in;
   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   diff;
   logic             ge;

   always_comb begin
      trial  = {rem_i, num_i[WIDTH-1]};
      diff   = trial - {1'b0, den_i};
      ge     = trial >= {1'b0, den_i};
      rem_in = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      quo_in = {quo_i[WIDTH-2:0], ge};
      num_in = {num_i[WIDTH-2:0], 1'b0};
      b_in   = {b_i[WIDTH-2:0], 1'b0};
      if (ctl_i.func == FUNC_MUL) begin
         acc_in = {acc_i[WIDTH-2:0], 1'b0} + (b_i[WIDTH-1] ? a_i : '0);
      end else begin
         acc_in = acc_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.vld <= 1'b0;
      end else if (en) begin
         ctl_ff.vld <= ctl_i.vld;
      end
      if (en) begin
         ctl_ff.func  <= ctl_i.func;
         ctl_ff.carry <= ctl_i.carry;
         ctl_ff.dz    <= ctl_i.dz;
         ctl_ff.sa    <= ctl_i.sa;
         ctl_ff.sb    <= ctl_i.sb;
         a_ff   <= a_i;
         b_ff   <= b_in;
         num_ff <= num_in;
         den_ff <= den_i;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         acc_ff <= acc_in;
      end
   end

   assign ctl_o = ctl_ff;
   assign a_o   = a_ff;
   assign b_o   = b_ff;
   assign num_o = num_ff;
   assign den_o = den_ff;
   assign rem_o = rem_ff;
   assign quo_o = quo_ff;
   assign acc_o = acc_ff;

endmodule

### hdl/integer_alu_add_sub_mul_div.sv
// top level of the pipelined integer alu: add, subtract, multiply, divide
//
// Request channel req_*: tuser carries the operation (0 add, 1 subtract,
// 2 multiply, 3 divide), tdata carries operand_a and operand_b.
// Response channel rsp_*: tdata carries result_value, remainder,
// carry_out and divide_by_zero.
// Every request gives exactly one response, in request order.
// The pipeline has one operand prep stage, a row of WIDTH
// identical cells that each retire one quotient bit and one multiplier
// bit, and one output register that applies the result signs.
// Throughput is one request per cycle unless stalled; the cell row sets latency.
// When the receiver stalls the whole pipeline holds and req_tready drops
// only once the output register is full; a waiting response never blocks
// the pipeline while the output register is free.
// Reset clears every valid bit; no response is pending after reset.
// A divide by zero returns quotient 0, the dividend as remainder and
// raises divide_by_zero.
module integer_alu_add_sub_mul_div #(
   parameter int WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((2*WIDTH+7)/8)*8-1:0]          req_tdata,  // operand_a, operand_b
   input  logic [1:0]                            req_tuser,  // func
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // result_value, remainder, carry_out, divide_by_zero
   output logic [((2*WIDTH+2+7)/8)*8-1:0]        rsp_tdata
);
   import ialu_pkg::*;

   localparam int RDW = ((2*WIDTH+2+7)/8)*8;

   logic en;
   logic [WIDTH-1:0] op_a, op_b, neg_a, neg_b;
   logic [WIDTH:0]   add_w, sub_w;
   func_type         func;

   ctl_type          ctl_s [0:WIDTH];
   logic [WIDTH-1:0] a_s   [0:WIDTH];
   logic [WIDTH-1:0] b_s   [0:WIDTH];
   logic [WIDTH-1:0] num_s [0:WIDTH];
   logic [WIDTH-1:0] den_s [0:WIDTH];
   logic [WIDTH-1:0] rem_s [0:WIDTH];
   logic [WIDTH-1:0] quo_s [0:WIDTH];
   logic [WIDTH-1:0] acc_s [0:WIDTH];

   ctl_type          ctl_ff;
   logic [WIDTH-1:0] a_ff, b_ff, num_ff, den_ff, acc_ff;
   ctl_type          ctl_in;
   logic [WIDTH-1:0] acc_in;

   logic             out_vld_ff;
   logic [WIDTH-1:0] out_val_ff, out_rem_ff, out_val_in, out_rem_in;
   logic             out_c_ff, out_dz_ff, out_c_in;
   ctl_type          ctl_l;

   assign en         = !out_vld_ff || rsp_tready;
   assign req_tready = en;

   // prep stage
   always_comb begin
      op_a  = req_tdata[WIDTH-1:0];
      op_b  = req_tdata[2*WIDTH-1:WIDTH];
      func  = func_type'(req_tuser);
      neg_a = '0 - op_a;
      neg_b = '0 - op_b;
      add_w = {1'b0, op_a} + {1'b0, op_b};
      sub_w = {1'b0, op_a} - {1'b0, op_b};
      ctl_in.vld  = req_tvalid;
      ctl_in.func = func;
      ctl_in.sa   = op_a[WIDTH-1];
      ctl_in.sb   = op_b[WIDTH-1];
      ctl_in.dz   = (func == FUNC_DIV) && (op_b == '0);
      case (func)
         FUNC_ADD: begin
            acc_in       = add_w[WIDTH-1:0];
            ctl_in.carry = add_w[WIDTH];
         end
         FUNC_SUB: begin
            acc_in       = sub_w[WIDTH-1:0];
            ctl_in.carry = sub_w[WIDTH];
         end
         default: begin
            acc_in       = '0;
            ctl_in.carry = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.vld <= 1'b0;
      end else if (en) begin
         ctl_ff.vld <= ctl_in.vld;
      end
      if (en) begin
         ctl_ff.func  <= ctl_in.func;
         ctl_ff.carry <= ctl_in.carry;
         ctl_ff.dz    <= ctl_in.dz;
         ctl_ff.sa    <= ctl_in.sa;
         ctl_ff.sb    <= ctl_in.sb;
         a_ff   <= op_a;
         b_ff   <= op_b;
         num_ff <= op_a[WIDTH-1] ? neg_a : op_a;
         den_ff <= op_b[WIDTH-1] ? neg_b : op_b;
         acc_ff <= acc_in;
      end
   end

   assign ctl_s[0] = ctl_ff;
   assign a_s[0]   = a_ff;
   assign b_s[0]   = b_ff;
   assign num_s[0] = num_ff;
   assign den_s[0] = den_ff;
   assign rem_s[0] = '0;
   assign quo_s[0] = '0;
   assign acc_s[0] = acc_ff;

   for (genvar i = 0; i < WIDTH; i++) begin : g_cell
      ialu_cell #(.WIDTH(WIDTH)) u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .ctl_i (ctl_s[i]),
         .a_i   (a_s[i]),
         .b_i   (b_s[i]),
         .num_i (num_s[i]),
         .den_i (den_s[i]),
         .rem_i (rem_s[i]),
         .quo_i (quo_s[i]),
         .acc_i (acc_s[i]),
         .ctl_o (ctl_s[i+1]),
         .a_o   (a_s[i+1]),
         .b_o   (b_s[i+1]),
         .num_o (num_s[i+1]),
         .den_o (den_s[i+1]),
         .rem_o (rem_s[i+1]),
         .quo_o (quo_s[i+1]),
         .acc_o (acc_s[i+1])
      );
   end

   // sign fix-up and output register
   always_comb begin
      ctl_l      = ctl_s[WIDTH];
      out_rem_in = '0;
      out_c_in   = 1'b0;
      case (ctl_l.func)
         FUNC_ADD, FUNC_SUB: begin
            out_val_in = acc_s[WIDTH];
            out_c_in   = ctl_l.carry;
         end
         FUNC_MUL: begin
            out_val_in = acc_s[WIDTH];
         end
         FUNC_DIV: begin
            if (ctl_l.dz) begin
               out_val_in = '0;
               out_rem_in = a_s[WIDTH];
            end else begin
               out_val_in = (ctl_l.sa ^ ctl_l.sb) ? '0 - quo_s[WIDTH] : quo_s[WIDTH];
               out_rem_in = ctl_l.sa ? '0 - rem_s[WIDTH] : rem_s[WIDTH];
            end
         end
         default: begin
            out_val_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= ctl_l.vld;
      end
      if (en) begin
         out_val_ff <= out_val_in;
         out_rem_ff <= out_rem_in;
         out_c_ff   <= out_c_in;
         out_dz_ff  <= ctl_l.dz;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = RDW'({out_dz_ff, out_c_ff, out_rem_ff, out_val_ff});

   a_dz_zero_quotient: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_dz_ff |-> out_val_ff == '0)
      else $error("divide by zero with nonzero quotient");

   a_carry_dz_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(out_c_ff && out_dz_ff))
      else $error("carry and divide by zero both set");

   a_rem_no_carry: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_rem_ff != '0 |-> !out_c_ff)
      else $error("remainder alongside carry");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled while output register free");

endmodule

### verif/integer_alu_add_sub_mul_div_tb.sv
// testbench for the pipelined integer alu: table-driven and random requests checked in order
`timescale 1ns / 100ps

module integer_alu_add_sub_mul_div_tb;
   import ialu_pkg::*;

   localparam int W = 32;
   localparam int REQ_W = ((2*W+7)/8)*8;
   localparam int RSP_W = ((2*W+2+7)/8)*8;
   localparam int N_RANDOM = 800;
   localparam int STALL_LIMIT = 2000;
   localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MINUS_ONE = {W{1'b1}};

   typedef struct packed {
      logic          dz;
      logic          carry;
      logic [W-1:0]  rem;
      logic [W-1:0]  value;
   } alu_result_type;

   typedef struct {
      func_type        func;
      logic [W-1:0]    a;
      logic [W-1:0]    b;
      logic            known;
      alu_result_type  res;
   } alu_row_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata;   // operand_a, operand_b
   logic [1:0]        req_tuser;   // func
   logic              rsp_tvalid;
   logic              rsp_tready;
   // result_value, remainder, carry_out, divide_by_zero
   logic [RSP_W-1:0]  rsp_tdata;

   alu_result_type expected_results[$];
   int errors = 0;
   int idle_cycles = 0;
   bit quiet = 0;
   alu_row_type rows[$];

   integer_alu_add_sub_mul_div #(.WIDTH(W)) u_top (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic alu_result_type alu_predict(func_type f, logic [W-1:0] a,
                                                  logic [W-1:0] b);
      alu_result_type r;
      logic [W:0] wide;
      logic [W-1:0] ma, mb, q, rm;
      r = '0;
      case (f)
         FUNC_ADD: begin
            wide = {1'b0, a} + {1'b0, b};
            r.value = wide[W-1:0];
            r.carry = wide[W];
         end
         FUNC_SUB: begin
            r.value = a - b;
            r.carry = a < b;
         end
         FUNC_MUL: r.value = a * b;
         default: begin
            if (b == '0) begin
               r.rem = a;
               r.dz = 1'b1;
            end else begin
               ma = a[W-1] ? -a : a;
               mb = b[W-1] ? -b : b;
               q = ma / mb;
               rm = ma % mb;
               r.value = (a[W-1] ^ b[W-1]) ? -q : q;
               r.rem = a[W-1] ? -rm : rm;
            end
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
   endtask

   task automatic add_row(func_type f, logic [W-1:0] a, logic [W-1:0] b, bit known = 0,
                          logic [W-1:0] v = 0, logic [W-1:0] rm = 0, logic c = 0,
                          logic z = 0);
      alu_row_type row;
      row.func = f;
      row.a = a;
      row.b = b;
      row.known = known;
      row.res = '{dz: z, carry: c, rem: rm, value: v};
      rows.push_back(row);
   endtask

   task automatic send_request(func_type f, logic [W-1:0] a, logic [W-1:0] b);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= f;
      req_tdata <= {{(REQ_W-2*W){1'b0}}, b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [W-1:0] random_operand();
      case ($urandom_range(0, 7))
         0: return MOST_NEG;
         1: return MOST_POS;
         2: return MINUS_ONE;
         3: return '0;
         4: return W'($urandom_range(0, 20)) - 10;
         5: return W'($urandom_range(0, 65535));
         default: return W'($urandom());
      endcase
   endfunction

   // push expectation at accept
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         expected_results.push_back(alu_predict(func_type'(req_tuser), req_tdata[W-1:0],
                                                req_tdata[2*W-1:W]));
   end

   always @(posedge clock) begin
      alu_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[2*W+1:0];
         if (expected_results.size() == 0) begin
            $display("unexpected response %h", rsp_tdata);
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (got.value !== want.value) report_mismatch("result_value", got.value, want.value);
            if (got.rem !== want.rem) report_mismatch("remainder", got.rem, want.rem);
            if (got.carry !== want.carry)
               report_mismatch("carry_out", W'(got.carry), W'(want.carry));
            if (got.dz !== want.dz)
               report_mismatch("divide_by_zero", W'(got.dz), W'(want.dz));
         end
      end
   end

   // watchdog on cycles with no request or response accepted
   always @(posedge clock) begin
      if (!reset && (req_tvalid && req_tready) || (!reset && rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int gap;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            rsp_tready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end else
            rsp_tready <= 1'b1;
      end
   end

   initial begin
      alu_result_type p;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = FUNC_ADD;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      add_row(FUNC_ADD, 0, 0, 1, 0, 0, 0, 0);
      add_row(FUNC_ADD, MINUS_ONE, 1, 1, 0, 0, 1, 0);
      add_row(FUNC_ADD, MOST_POS, 1, 1, MOST_NEG, 0, 0, 0);
      add_row(FUNC_ADD, MINUS_ONE, MINUS_ONE);
      add_row(FUNC_SUB, 5, 3, 1, 2, 0, 0, 0);
      add_row(FUNC_SUB, 0, 1, 1, MINUS_ONE, 0, 1, 0);
      add_row(FUNC_SUB, MOST_NEG, MOST_POS, 1, 1, 0, 0, 0);
      add_row(FUNC_SUB, 7, 7, 1, 0, 0, 0, 0);
      add_row(FUNC_MUL, MINUS_ONE, MINUS_ONE, 1, 1, 0, 0, 0);
      add_row(FUNC_MUL, MOST_NEG, MINUS_ONE, 1, MOST_NEG, 0, 0, 0);
      add_row(FUNC_MUL, MOST_POS, MOST_POS);
      add_row(FUNC_MUL, -3, 7);
      add_row(FUNC_DIV, 7, 0, 1, 0, 7, 0, 1);
      add_row(FUNC_DIV, MOST_NEG, 0, 1, 0, MOST_NEG, 0, 1);
      add_row(FUNC_DIV, MOST_NEG, MINUS_ONE, 1, MOST_NEG, 0, 0, 0);
      add_row(FUNC_DIV, MOST_NEG, MOST_NEG, 1, 1, 0, 0, 0);
      add_row(FUNC_DIV, 5, MOST_NEG, 1, 0, 5, 0, 0);
      add_row(FUNC_DIV, -7, 2, 1, -3, -1, 0, 0);
      add_row(FUNC_DIV, 7, -2, 1, -3, 1, 0, 0);
      add_row(FUNC_DIV, -7, -2, 1, 3, -1, 0, 0);
      add_row(FUNC_DIV, MOST_POS, 1);
      add_row(FUNC_DIV, MINUS_ONE, MINUS_ONE);

      foreach (rows[i]) begin
         if (rows[i].known) begin
            p = alu_predict(rows[i].func, rows[i].a, rows[i].b);
            if (p !== rows[i].res) begin
               $display("table row %0d disagrees with prediction", i);
               errors++;
            end
         end
         send_request(rows[i].func, rows[i].a, rows[i].b);
      end

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i > N_RANDOM - 100) quiet = 1;
         send_request(func_type'($urandom_range(0, 3)), random_operand(), random_operand());
      end
      req_tvalid <= 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (2*W + 8) @(posedge clock);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
